>>> rtl/core/fcca_pkg.sv
`default_nettype none
package fcca_pkg;

	localparam int NUM_CLUSTERS = 1024;
	localparam int AW = $clog2(NUM_CLUSTERS);
	localparam int SW = AW + 1;
	localparam int KIND_W = 3;
	localparam int CL_W = 10;
	localparam int STATUS_W = 2;
	localparam int VAL_W = 11;
	localparam int CNT_W = 11;
	localparam int RES_W = 5;

	localparam logic [VAL_W-1:0] END_MARK = '1;
	localparam logic [RES_W-1:0] RESERVED_RST = RES_W'(3);

	localparam logic [STATUS_W-1:0] ST_OK = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_FULL = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_BROKEN = STATUS_W'(2);

	localparam logic [KIND_W-1:0] K_ALLOC = KIND_W'(0);
	localparam logic [KIND_W-1:0] K_EXTEND = KIND_W'(1);
	localparam logic [KIND_W-1:0] K_FREE_CHAIN = KIND_W'(2);
	localparam logic [KIND_W-1:0] K_FREE_ONE = KIND_W'(3);
	localparam logic [KIND_W-1:0] K_COUNT = KIND_W'(4);
	localparam logic [KIND_W-1:0] K_READ = KIND_W'(5);
	localparam logic [KIND_W-1:0] K_FORMAT = KIND_W'(6);

	typedef enum logic [3:0] {
		OP_ALLOC,
		OP_EXTEND,
		OP_FREE_CHAIN,
		OP_FREE_ONE,
		OP_COUNT,
		OP_READ,
		OP_FORMAT,
		OP_NOP,
		OP_FULL,
		OP_BROKEN
	} op_t;

	typedef struct packed {
		op_t op;
		logic [AW-1:0] cl;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD,
		S_EV,
		S_LINK,
		S_FMT,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/fcca_ifs.sv
`default_nettype none
interface fcca_in_if import fcca_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [CL_W-1:0] cluster;
	modport source (output valid, kind, cluster, input ready);
	modport sink (input valid, kind, cluster, output ready);
endinterface

interface fcca_out_if import fcca_pkg::*; ();
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0] value;
	logic [CNT_W-1:0] count;
	modport source (output valid, status, value, count, input ready);
	modport sink (input valid, status, value, count, output ready);
endinterface

interface fcca_cfg_if import fcca_pkg::*; ();
	logic valid;
	logic ready;
	logic [RES_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fcca_front.sv
`default_nettype none
module fcca_front import fcca_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	fcca_in_if.sink in_ch,
	output qhead_t head,
	input wire logic pop
);
	cmd_t ent_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;
	logic push;
	logic in_range;
	cmd_t cmd;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign in_range = (32'(in_ch.cluster) < NUM_CLUSTERS);

	// classify the command, settling out-of-range cases here
	always_comb begin
		cmd.cl = AW'(in_ch.cluster);
		case (in_ch.kind)
			K_ALLOC: cmd.op = OP_ALLOC;
			K_EXTEND: cmd.op = in_range ? OP_EXTEND : OP_FULL;
			K_FREE_CHAIN: cmd.op = in_range ? OP_FREE_CHAIN : OP_BROKEN;
			K_FREE_ONE: cmd.op = in_range ? OP_FREE_ONE : OP_NOP;
			K_COUNT: cmd.op = OP_COUNT;
			K_READ: cmd.op = in_range ? OP_READ : OP_NOP;
			K_FORMAT: cmd.op = OP_FORMAT;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd = ent_q[rd_ptr_q];
endmodule
`default_nettype wire

>>> rtl/core/fcca_back.sv
`default_nettype none
module fcca_back import fcca_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input qhead_t head,
	output logic pop,
	fcca_cfg_if.sink cfg,
	fcca_out_if.source out_ch
);
	logic [VAL_W-1:0] mem [NUM_CLUSTERS];
	logic [VAL_W-1:0] rd_q;

	state_t state_q, state_d;
	op_t op_q;
	logic [AW-1:0] cl_q;
	logic [AW-1:0] addr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0] steps_q;
	logic [RES_W-1:0] res_q;
	logic [STATUS_W-1:0] r_status_q;
	logic [VAL_W-1:0] r_value_q;
	logic out_valid_q;
	logic [STATUS_W-1:0] o_status_q;
	logic [VAL_W-1:0] o_value_q;
	logic [CNT_W-1:0] o_count_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [VAL_W-1:0] wdata;
	logic load_out;
	logic last;
	logic rd_zero;
	logic [SW-1:0] steps_nx;
	logic chain_stop;

	assign last = (addr_q == AW'(NUM_CLUSTERS - 1));
	assign rd_zero = (rd_q == '0);
	assign steps_nx = steps_q + SW'(1);
	assign chain_stop = (steps_nx == SW'(NUM_CLUSTERS)) ||
		(32'(rd_q) >= NUM_CLUSTERS);
	assign cfg.ready = 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (last) state_d = S_IDLE;
			S_IDLE: begin
				if (head.valid) begin
					case (head.cmd.op)
						OP_ALLOC, OP_EXTEND, OP_FREE_CHAIN, OP_COUNT, OP_READ:
							state_d = S_RD;
						OP_FORMAT: state_d = S_FMT;
						default: state_d = S_RESP;
					endcase
				end
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				case (op_q)
					OP_ALLOC: state_d = (rd_zero || last) ? S_RESP : S_RD;
					OP_EXTEND: begin
						if (rd_zero) begin
							state_d = (addr_q != cl_q) ? S_LINK : S_RESP;
						end else begin
							state_d = last ? S_RESP : S_RD;
						end
					end
					OP_FREE_CHAIN: begin
						if (rd_zero || rd_q == END_MARK || chain_stop) begin
							state_d = S_RESP;
						end else begin
							state_d = S_RD;
						end
					end
					OP_COUNT: state_d = last ? S_RESP : S_RD;
					default: state_d = S_RESP;
				endcase
			end
			S_LINK: state_d = S_RESP;
			S_FMT: if (last) state_d = S_RESP;
			S_RESP: if (!out_valid_q || out_ch.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = addr_q;
		wdata = '0;
		pop = 1'b0;
		load_out = 1'b0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wdata = (32'(addr_q) < 32'(RESERVED_RST)) ? END_MARK : '0;
			end
			S_IDLE: begin
				pop = head.valid;
				if (head.valid && head.cmd.op == OP_FREE_ONE) begin
					we = 1'b1;
					waddr = head.cmd.cl;
				end
			end
			S_EV: begin
				case (op_q)
					OP_ALLOC, OP_EXTEND: begin
						we = rd_zero;
						wdata = END_MARK;
					end
					OP_FREE_CHAIN: we = !rd_zero;
					default: we = 1'b0;
				endcase
			end
			S_LINK: begin
				we = 1'b1;
				waddr = cl_q;
				wdata = VAL_W'(addr_q);
			end
			S_FMT: begin
				we = 1'b1;
				wdata = (32'(addr_q) < 32'(res_q)) ? END_MARK : '0;
			end
			S_RESP: load_out = !out_valid_q || out_ch.ready;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= head.cmd.op;
				cl_q <= head.cmd.cl;
				cnt_q <= '0;
				steps_q <= '0;
				r_value_q <= '0;
				case (head.cmd.op)
					OP_ALLOC, OP_EXTEND: r_status_q <= ST_FULL;
					OP_FULL: r_status_q <= ST_FULL;
					OP_FREE_CHAIN, OP_BROKEN: r_status_q <= ST_BROKEN;
					default: r_status_q <= ST_OK;
				endcase
			end
			S_EV: begin
				case (op_q)
					OP_ALLOC, OP_EXTEND: begin
						if (rd_zero) begin
							r_status_q <= ST_OK;
							r_value_q <= VAL_W'(addr_q);
						end
					end
					OP_FREE_CHAIN: begin
						if (!rd_zero) begin
							cnt_q <= cnt_q + CNT_W'(1);
							steps_q <= steps_nx;
							if (rd_q == END_MARK) begin
								r_status_q <= ST_OK;
							end
						end
					end
					OP_COUNT: if (!rd_zero) cnt_q <= cnt_q + CNT_W'(1);
					OP_READ: r_value_q <= rd_q;
					default: r_value_q <= r_value_q;
				endcase
			end
			default: cl_q <= cl_q;
		endcase
		if (load_out) begin
			o_status_q <= r_status_q;
			o_value_q <= r_value_q;
			o_count_q <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q <= '0;
			res_q <= RESERVED_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				res_q <= cfg.data;
			end
			case (state_q)
				S_CLEAR, S_FMT: addr_q <= addr_q + AW'(1);
				S_IDLE: begin
					case (head.cmd.op)
						OP_EXTEND, OP_FREE_CHAIN, OP_READ: addr_q <= head.cmd.cl;
						default: addr_q <= '0;
					endcase
				end
				S_EV: begin
					if (op_q == OP_FREE_CHAIN) begin
						addr_q <= AW'(rd_q);
					end else if (!((op_q == OP_ALLOC || op_q == OP_EXTEND) && rd_zero)) begin
						addr_q <= addr_q + AW'(1);
					end
				end
				default: addr_q <= addr_q;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = o_status_q;
	assign out_ch.value = o_value_q;
	assign out_ch.count = o_count_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == S_IDLE) else $error("pop outside idle");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !out_valid_q && !pop) else $error("activity during clear");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q) else $error("result lost");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD && op_q == OP_FREE_CHAIN |-> 32'(steps_q) < NUM_CLUSTERS)
		else $error("chain walk overrun");
endmodule
`default_nettype wire

>>> rtl/core/fat_cluster_chain_allocator_core.sv
// channel   dir  signals
// in_ch     in   valid ready kind cluster
// out_ch    out  valid ready status value count
// cfg       in   valid ready data (reserved_entries)
// after reset a clearing pass over all entries runs; commands wait in the queue
// allocate, extend, count: from idle, a read and an evaluate state per entry
// visited, then the result; extend writes the link in a link state before it
// free chain: the same per link; format writes all entries; read: one visit
// one memory read port splits each visit; a two-entry queue takes commands
// while the back end works and the result register waits on out_ch.ready
`default_nettype none
module fat_cluster_chain_allocator_core import fcca_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	fcca_in_if.sink in_ch,
	fcca_out_if.source out_ch,
	fcca_cfg_if.sink cfg
);
	qhead_t head;
	logic pop;

	fcca_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.head(head),
		.pop(pop)
	);

	fcca_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.cfg(cfg),
		.out_ch(out_ch)
	);
endmodule
`default_nettype wire

>>> tb/fcca_checker.sv
`default_nettype none
module fcca_checker import fcca_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	fcca_in_if in_ch,
	fcca_out_if out_ch,
	fcca_cfg_if cfg,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
	} answer_t;

	answer_t answers_due[$];
	logic [VAL_W-1:0] links [NUM_CLUSTERS];
	logic [RES_W-1:0] reserved;

	function automatic void format_links();
		int lim;
		lim = (int'(reserved) > NUM_CLUSTERS) ? NUM_CLUSTERS : int'(reserved);
		for (int i = 0; i < NUM_CLUSTERS; i++) begin
			links[i] = (i < lim) ? END_MARK : '0;
		end
	endfunction

	function automatic answer_t run_command(logic [KIND_W-1:0] kind, logic [CL_W-1:0] cl);
		answer_t a;
		int cur;
		int steps;
		int used;
		logic [VAL_W-1:0] v;
		a = '0;
		used = 0;
		case (kind)
			K_ALLOC: begin
				a.status = ST_FULL;
				for (int i = 0; i < NUM_CLUSTERS; i++) begin
					if (links[i] == '0) begin
						links[i] = END_MARK;
						a.value = VAL_W'(i);
						a.status = ST_OK;
						break;
					end
				end
			end
			K_EXTEND: begin
				a.status = ST_FULL;
				for (int i = int'(cl); i < NUM_CLUSTERS; i++) begin
					if (links[i] == '0) begin
						links[cl] = VAL_W'(i);
						links[i] = END_MARK;
						a.value = VAL_W'(i);
						a.status = ST_OK;
						break;
					end
				end
			end
			K_FREE_CHAIN: begin
				a.status = ST_BROKEN;
				cur = int'(cl);
				steps = 0;
				while (steps < NUM_CLUSTERS) begin
					if (cur >= NUM_CLUSTERS) break;
					v = links[cur];
					if (v == '0) break;
					links[cur] = '0;
					used++;
					steps++;
					if (v == END_MARK) begin
						a.status = ST_OK;
						break;
					end
					cur = int'(v);
				end
				a.count = CNT_W'(used);
			end
			K_FREE_ONE: links[cl] = '0;
			K_COUNT: begin
				for (int i = 0; i < NUM_CLUSTERS; i++) begin
					if (links[i] != '0) used++;
				end
				a.count = CNT_W'(used);
			end
			K_READ: a.value = links[cl];
			K_FORMAT: format_links();
			default: ;
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		answer_t want;
		if (!arst_n) begin
			reserved = RESERVED_RST;
			format_links();
			answers_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.status, out_ch.value, out_ch.count};
				if (answers_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result transaction %h", $realtime, got);
				end else begin
					want = answers_due.pop_front();
					if (got != want) begin
						errors++;
						if (errors <= 10)
							$display("%0t: status %0d/%0d value %0d/%0d count %0d/%0d (exp/act)",
								$realtime, want.status, got.status, want.value, got.value,
								want.count, got.count);
					end
				end
			end
			if (cfg.valid && cfg.ready) reserved = cfg.data;
			if (in_ch.valid && in_ch.ready)
				answers_due.push_back(run_command(in_ch.kind, in_ch.cluster));
			pending = answers_due.size();
		end
	end
endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
	import fcca_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic quiet;
	logic hold_req;
	logic hold_done;
	int errors;
	int pending;
	int cycles;

	fcca_in_if in_ch();
	fcca_out_if out_ch();
	fcca_cfg_if cfg();

	fat_cluster_chain_allocator_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	fcca_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 6000000) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ch.ready = 1'b0;
				repeat (600) @(negedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			out_ch.ready = 1'b1;
		end
	end

	task automatic send(logic [KIND_W-1:0] k, logic [CL_W-1:0] c);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.kind = k;
		in_ch.cluster = c;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic set_reserved(logic [RES_W-1:0] v);
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg.valid = 1'b1;
		cfg.data = v;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
		send(K_FORMAT, CL_W'($urandom));
	endtask

	function automatic logic [CL_W-1:0] pick_cluster();
		return ($urandom_range(0, 9) < 7) ? CL_W'($urandom_range(0, 127)) : CL_W'($urandom);
	endfunction

	initial begin
		int w;
		logic [KIND_W-1:0] k;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = '0;
		in_ch.cluster = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		send(K_READ, 10'd0);
		send(K_READ, 10'd1023);
		send(K_ALLOC, 10'd0);
		send(K_ALLOC, 10'd0);
		send(K_EXTEND, 10'd3);
		send(K_EXTEND, 10'd3);
		send(K_EXTEND, 10'd1023);
		send(K_EXTEND, 10'd1023);
		send(K_READ, 10'd3);
		send(K_FREE_ONE, 10'd5);
		send(K_FREE_CHAIN, 10'd3);
		send(K_FREE_CHAIN, 10'd500);
		send(K_FREE_CHAIN, 10'd1023);
		send(K_FREE_ONE, 10'd0);
		send(K_COUNT, 10'd0);
		send(KIND_W'(7), 10'd1023);
		send(K_FORMAT, 10'd0);
		set_reserved(5'd0);
		send(K_COUNT, 10'd0);
		send(K_ALLOC, 10'd0);
		set_reserved(5'd31);
		send(K_FREE_CHAIN, 10'd0);
		send(K_COUNT, 10'd0);
		set_reserved(5'd16);

		for (int i = 0; i < 560; i++) begin
			if (i == 140) set_reserved(5'($urandom_range(0, 31)));
			if (i == 300) set_reserved(5'($urandom_range(0, 16)));
			if (i == 440) set_reserved(5'd3);
			if (i == 250) hold_req = 1'b1;
			if (i >= 480) quiet = 1'b1;
			w = $urandom_range(0, 99);
			if (i >= 250 && i < 275) k = K_READ;
			else if (w < 30) k = K_ALLOC;
			else if (w < 52) k = K_EXTEND;
			else if (w < 66) k = K_FREE_CHAIN;
			else if (w < 74) k = K_FREE_ONE;
			else if (w < 78) k = K_COUNT;
			else if (w < 95) k = K_READ;
			else if (w < 97) k = K_FORMAT;
			else k = KIND_W'(7);
			send(k, pick_cluster());
		end
		in_ch.valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
rtl/core/fcca_pkg.sv
rtl/core/fcca_ifs.sv
rtl/core/fcca_front.sv
rtl/core/fcca_back.sv
rtl/core/fat_cluster_chain_allocator_core.sv
tb/fcca_checker.sv
tb/testbench.sv
